// File: design/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants for the best-fit block allocator: header marks, status
// codes, request modes, field widths and default arena size.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int ARENA_BYTES_DEF = 32768;
   localparam int HDR_BYTES       = 5;
   localparam int OFS_W           = 15;
   localparam int STATUS_W        = 2;
   localparam int MARK_W          = 2;
   localparam int NEED_W          = OFS_W + 1;

   localparam logic [MARK_W-1:0] MARK_NONE  = 2'd0;
   localparam logic [MARK_W-1:0] MARK_FREE  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_ALLOC = 2'd2;
   localparam logic [MARK_W-1:0] MARK_END   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

endpackage

// File: design/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-port RAM, one read per cycle plus a write in that same cycle when we is high, registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/best_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over an arena of headed blocks kept in a header RAM.
// ----------------------------------------------------------------------------
// Raise start while busy is low to hand in one item: an allocate (mode 0)
// or a free (mode 1). The block walks the header chain from offset 0, one
// header at a time: a RAM read in S_RD, then evaluation in S_EV through
// one shared adder and comparator. An allocate visits every block and then
// the end mark before it writes the chosen header, and goes on through
// S_SPLIT when a remainder is split off. A free walks the blocks up to and
// including the target, or all blocks when the offset is unknown. A
// zero-size allocate is answered in the cycle after acceptance without
// raising busy. The result shows on the rsp_ ports for exactly one cycle
// with rsp_valid high and must be taken then, since the receiver cannot
// stall; busy is low in that same cycle, so a new item may start right
// away. After reset the block writes the initial free block in S_INIT0
// and the end mark in S_INIT1, with busy high.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
   parameter int ARENA_BYTES = bfa_pkg::ARENA_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [bfa_pkg::OFS_W-1:0]      req_request_bytes,
   input  logic [bfa_pkg::OFS_W-1:0]      req_free_offset,
   output logic                           rsp_valid,
   output logic [bfa_pkg::OFS_W-1:0]      rsp_block_offset,
   output logic [bfa_pkg::STATUS_W-1:0]   rsp_status
);
   import bfa_pkg::*;

   localparam int AW = $clog2(ARENA_BYTES);   // header address
   localparam int PW = AW + 1;                // walk pointer, may reach arena end
   localparam int SW = AW;                    // block size
   localparam int DW = MARK_W + SW;
   localparam int CW = (PW > NEED_W) ? PW + 1 : NEED_W + 1;

   typedef enum logic [2:0] {
      S_INIT0, S_INIT1, S_IDLE, S_RD, S_EV, S_NRD, S_NEV, S_SPLIT
   } state_type;

   state_type             state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic [NEED_W-1:0]     need_ff, need_in;
   logic [OFS_W-1:0]      target_ff, target_in;
   logic [PW-1:0]         at_ff, at_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         best_ff, best_in;
   logic [SW-1:0]         best_size_ff, best_size_in;
   logic                  prev_has_ff, prev_has_in;
   logic                  prev_free_ff, prev_free_in;
   logic [AW-1:0]         prev_at_ff, prev_at_in;
   logic [SW-1:0]         prev_size_ff, prev_size_in;
   logic [SW-1:0]         cur_size_ff, cur_size_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OFS_W-1:0]      rsp_ofs_ff, rsp_ofs_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_addr;
   logic [DW-1:0]         ram_wdata, ram_rdata;
   logic [MARK_W-1:0]     rd_mark;
   logic [SW-1:0]         rd_size;

   // shared walk adder and fit compare
   logic [PW-1:0]         sum;
   logic [SW-1:0]         add_b;
   logic                  at_stop;
   logic                  fits;
   logic [CW-1:0]         rest_w;
   logic [SW-1:0]         rest;
   logic                  do_split;
   logic [31:0]           best_wide;
   logic [SW-1:0]         merged;

   bfa_ram #(.WIDTH(DW), .DEPTH(2 ** AW)) u_hdr (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rd_mark   = ram_rdata[DW-1 -: MARK_W];
   assign rd_size   = ram_rdata[SW-1:0];
   assign sum       = at_ff + PW'(add_b);
   assign at_stop   = at_ff >= PW'(ARENA_BYTES);
   assign fits      = CW'(rd_size) >= CW'(need_ff);
   assign rest_w    = CW'(best_size_ff) - CW'(need_ff);
   assign rest      = rest_w[SW-1:0];
   assign do_split  = rest_w >= CW'(HDR_BYTES);
   assign best_wide = 32'(best_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      need_in       = need_ff;
      target_in     = target_ff;
      at_in         = at_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_size_in  = best_size_ff;
      prev_has_in   = prev_has_ff;
      prev_free_in  = prev_free_ff;
      prev_at_in    = prev_at_ff;
      prev_size_in  = prev_size_ff;
      cur_size_in   = cur_size_ff;
      rsp_valid_in  = 1'b0;
      rsp_ofs_in    = rsp_ofs_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_addr      = at_ff[AW-1:0];
      ram_wdata     = {MARK_NONE, SW'(0)};
      add_b         = rd_size;
      merged        = cur_size_ff + ((rd_mark == MARK_FREE) ? rd_size : SW'(0));

      case (state_ff)
         S_INIT0: begin
            // lay down the single free block
            ram_we    = 1'b1;
            ram_addr  = AW'(0);
            ram_wdata = {MARK_FREE, SW'(ARENA_BYTES - 1)};
            state_in  = S_INIT1;
         end
         S_INIT1: begin
            ram_we    = 1'b1;
            ram_addr  = AW'(ARENA_BYTES - 1);
            ram_wdata = {MARK_END, SW'(0)};
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               mode_in     = req_mode;
               need_in     = NEED_W'(req_request_bytes) + NEED_W'(HDR_BYTES);
               target_in   = req_free_offset;
               at_in       = PW'(0);
               found_in    = 1'b0;
               prev_has_in = 1'b0;
               if (req_mode == MODE_ALLOC && req_request_bytes == '0) begin
                  // zero size: answer at once
                  rsp_valid_in  = 1'b1;
                  rsp_ofs_in    = '0;
                  rsp_status_in = ST_NOFIT;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (at_stop) begin
               if (mode_ff == MODE_FREE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_ofs_in    = '0;
                  rsp_status_in = ST_BADADDR;
                  state_in      = S_IDLE;
               end else if (!found_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_ofs_in    = '0;
                  rsp_status_in = ST_NOFIT;
                  state_in      = S_IDLE;
               end else begin
                  ram_we    = 1'b1;
                  ram_addr  = best_ff;
                  ram_wdata = {MARK_ALLOC, do_split ? SW'(need_ff) : best_size_ff};
                  if (do_split) begin
                     state_in = S_SPLIT;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_ofs_in    = best_wide[OFS_W-1:0];
                     rsp_status_in = ST_DONE;
                     state_in      = S_IDLE;
                  end
               end
            end else begin
               state_in = S_EV;
            end
         end
         S_EV: begin
            if (mode_ff == MODE_ALLOC) begin
               if (rd_mark == MARK_END || rd_size == '0) begin
                  if (rd_mark != MARK_END && rd_mark == MARK_FREE && fits &&
                      (!found_ff || rd_size < best_size_ff)) begin
                     found_in     = 1'b1;
                     best_in      = at_ff[AW-1:0];
                     best_size_in = rd_size;
                  end
                  // close the walk: force the stop test in S_RD
                  at_in    = PW'(ARENA_BYTES);
                  state_in = S_RD;
               end else begin
                  if (rd_mark == MARK_FREE && fits &&
                      (!found_ff || rd_size < best_size_ff)) begin
                     found_in     = 1'b1;
                     best_in      = at_ff[AW-1:0];
                     best_size_in = rd_size;
                  end
                  at_in    = sum;
                  state_in = S_RD;
               end
            end else begin
               if (32'(at_ff) == 32'(target_ff)) begin
                  if (rd_mark == MARK_END) begin
                     rsp_valid_in  = 1'b1;
                     rsp_ofs_in    = '0;
                     rsp_status_in = ST_BADADDR;
                     state_in      = S_IDLE;
                  end else begin
                     cur_size_in = rd_size;
                     state_in    = S_NRD;
                  end
               end else if (rd_mark == MARK_END || rd_size == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_ofs_in    = '0;
                  rsp_status_in = ST_BADADDR;
                  state_in      = S_IDLE;
               end else begin
                  prev_has_in  = 1'b1;
                  prev_free_in = (rd_mark == MARK_FREE);
                  prev_at_in   = at_ff[AW-1:0];
                  prev_size_in = rd_size;
                  at_in        = sum;
                  state_in     = S_RD;
               end
            end
         end
         S_NRD: begin
            // look at the successor header
            add_b    = cur_size_ff;
            at_in    = sum;
            ram_addr = sum[AW-1:0];
            merged   = cur_size_ff;
            if (sum >= PW'(ARENA_BYTES)) begin
               ram_we = 1'b1;
               if (prev_has_ff && prev_free_ff) begin
                  ram_addr  = prev_at_ff;
                  ram_wdata = {MARK_FREE, prev_size_ff + merged};
               end else begin
                  ram_addr  = at_ff[AW-1:0];
                  ram_wdata = {MARK_FREE, merged};
               end
               rsp_valid_in  = 1'b1;
               rsp_ofs_in    = '0;
               rsp_status_in = ST_DONE;
               state_in      = S_IDLE;
            end else begin
               at_in    = at_ff;
               state_in = S_NEV;
            end
         end
         S_NEV: begin
            ram_we = 1'b1;
            if (prev_has_ff && prev_free_ff) begin
               ram_addr  = prev_at_ff;
               ram_wdata = {MARK_FREE, prev_size_ff + merged};
            end else begin
               ram_addr  = at_ff[AW-1:0];
               ram_wdata = {MARK_FREE, merged};
            end
            rsp_valid_in  = 1'b1;
            rsp_ofs_in    = '0;
            rsp_status_in = ST_DONE;
            state_in      = S_IDLE;
         end
         S_SPLIT: begin
            // hand the remainder back as a new free block
            ram_we        = 1'b1;
            ram_addr      = best_ff + AW'(need_ff);
            ram_wdata     = {MARK_FREE, rest};
            rsp_valid_in  = 1'b1;
            rsp_ofs_in    = best_wide[OFS_W-1:0];
            rsp_status_in = ST_DONE;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      need_ff       <= need_in;
      target_ff     <= target_in;
      at_ff         <= at_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_size_ff  <= best_size_in;
      prev_has_ff   <= prev_has_in;
      prev_free_ff  <= prev_free_in;
      prev_at_ff    <= prev_at_in;
      prev_size_ff  <= prev_size_in;
      cur_size_ff   <= cur_size_in;
      rsp_ofs_ff    <= rsp_ofs_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_offset = rsp_ofs_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
